/* design/mtlru_pkg.sv */
// ----------------------------------------------------------------------------
// mtlru_pkg: shared constants for the multi-tier LRU cache
// Default sizes, configuration register indexes and register field widths.
// ----------------------------------------------------------------------------
package mtlru_pkg;

    // default geometry
    localparam int DEF_MAX_TIERS = 4;
    localparam int DEF_WAYS      = 8;
    localparam int DEF_KEY_BITS  = 32;
    localparam int DEF_DATA_BITS = 32;

    // configuration register file
    localparam int NUM_CAP_REGS = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 4;
    localparam int TIERS_W      = 3;
    localparam int CAP_W        = 4;

    localparam logic [CFG_IDX_W-1:0] REG_TIERS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAP0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAP1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAP2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAP3  = 3'd4;

    localparam logic [TIERS_W-1:0] TIERS_RESET = 3'd3;
    localparam logic [CAP_W-1:0]   CAP_RESET   = 4'd2;

endpackage

/* design/mtlru_slots.sv */
// ----------------------------------------------------------------------------
// mtlru_slots: slot valid bits and recency ranks
// Keeps one valid bit and one age per slot, applies remove and push
// operations to one tier, and reports fill count, oldest way and first free
// way of a queried tier.
// ----------------------------------------------------------------------------
module mtlru_slots
    import mtlru_pkg::*;
#(
    parameter int MAX_TIERS = DEF_MAX_TIERS,
    parameter int WAYS      = DEF_WAYS,
    localparam int TIER_W   = (MAX_TIERS > 1) ? $clog2(MAX_TIERS) : 1,
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1,
    localparam int CNT_W    = $clog2(WAYS + 1)
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               remove_en,
    input  logic                               push_en,
    input  logic [TIER_W-1:0]                  op_tier,
    input  logic [WAY_W-1:0]                   op_way,
    input  logic [TIER_W-1:0]                  query_tier,
    output logic [MAX_TIERS-1:0][WAYS-1:0]     valid,
    output logic [CNT_W-1:0]                   count,
    output logic [WAY_W-1:0]                   oldest_way,
    output logic [WAY_W-1:0]                   free_way
);

    localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [MAX_TIERS-1:0][WAYS-1:0]             valid_reg, valid_next;
    logic [MAX_TIERS-1:0][WAYS-1:0][AGE_W-1:0]  age_reg, age_next;
    logic [AGE_W-1:0]                           op_age;
    logic [AGE_W-1:0]                           top_age;
    logic                                       free_seen;

    assign valid  = valid_reg;
    assign op_age = age_reg[op_tier][op_way];

    // apply remove or push to the lanes of the addressed tier
    always_comb
    begin
        valid_next = valid_reg;
        age_next   = age_reg;
        for (int t = 0; t < MAX_TIERS; t++)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (TIER_W'(t) == op_tier)
                begin
                    if (remove_en)
                    begin
                        if (WAY_W'(w) == op_way)
                        begin
                            valid_next[t][w] = 1'b0;
                            age_next[t][w]   = '0;
                        end
                        else if (valid_reg[t][w] && age_reg[t][w] > op_age)
                        begin
                            age_next[t][w] = age_reg[t][w] - 1'b1;
                        end
                    end
                    else if (push_en)
                    begin
                        if (WAY_W'(w) == op_way)
                        begin
                            valid_next[t][w] = 1'b1;
                            age_next[t][w]   = '0;
                        end
                        else if (valid_reg[t][w])
                        begin
                            age_next[t][w] = age_reg[t][w] + 1'b1;
                        end
                    end
                end
            end
        end
    end

    // hold slot bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            age_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
        end
    end

    // count entries of the queried tier
    always_comb
    begin
        count = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            count = count + CNT_W'(valid_reg[query_tier][w]);
        end
    end

    // ranks in a tier are distinct, so the oldest holds rank count-1
    assign top_age = AGE_W'(count - 1'b1);

    always_comb
    begin
        oldest_way = '0;
        free_way   = '0;
        free_seen  = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (valid_reg[query_tier][w] && age_reg[query_tier][w] == top_age)
            begin
                oldest_way = WAY_W'(w);
            end
            if (!valid_reg[query_tier][w] && !free_seen)
            begin
                free_way  = WAY_W'(w);
                free_seen = 1'b1;
            end
        end
    end

endmodule

/* design/multi_tier_lru_cache.sv */
// ----------------------------------------------------------------------------
// multi_tier_lru_cache: chain of LRU tiers with demotion
// Key/value store of MAX_TIERS fully associative tiers; entries demote down
// the chain and fall off the last active tier.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with mode, key and data_in while busy is low; the item is
//   taken at that edge and busy rises. One result follows per item: done is
//   high for a single cycle with hit, hit_tier, data_out, dropped,
//   dropped_key and dropped_data. The receiver cannot stall; take the result
//   in that cycle. A new item may start in the cycle done is high.
//   Steps: a key scan over all MAX_TIERS*WAYS_PER_TIER slots (one slot per
//   cycle through the key/data memory read port), a decide step, then an
//   insert and a shift per tier that demotes and an insert for the entry.
//   A get that misses ends right after the scan.
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are
//   always taken; write them only while no item is in flight.
//   Reset empties the store at once (valid bits clear) and loads 3 tiers of
//   capacity 2 each.
// ----------------------------------------------------------------------------
module multi_tier_lru_cache
    import mtlru_pkg::*;
#(
    parameter int MAX_TIERS     = DEF_MAX_TIERS,
    parameter int WAYS_PER_TIER = DEF_WAYS,
    parameter int KEY_BITS      = DEF_KEY_BITS,
    parameter int DATA_BITS     = DEF_DATA_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         mode,
    input  logic signed [KEY_BITS-1:0]   key,
    input  logic signed [DATA_BITS-1:0]  data_in,
    output logic                         done,
    output logic                         hit,
    output logic [1:0]                   hit_tier,
    output logic signed [DATA_BITS-1:0]  data_out,
    output logic                         dropped,
    output logic signed [KEY_BITS-1:0]   dropped_key,
    output logic signed [DATA_BITS-1:0]  dropped_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int WAYS     = WAYS_PER_TIER;
    localparam int SLOTS    = MAX_TIERS * WAYS;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TIER_W   = (MAX_TIERS > 1) ? $clog2(MAX_TIERS) : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W    = $clog2(WAYS + 1);
    localparam int LVL_W    = $clog2(MAX_TIERS + 1);
    localparam int ENTRY_W  = KEY_BITS + DATA_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_INSERT,
        ST_SHIFT
    } state_t;

    state_t                      state_reg;
    logic                        mode_reg;
    logic [KEY_BITS-1:0]         key_reg;
    logic [DATA_BITS-1:0]        data_reg;
    logic                        iss_on_reg;
    logic [TIER_W-1:0]           iss_tier_reg;
    logic [WAY_W-1:0]            iss_way_reg;
    logic                        cmp_vld_reg;
    logic [TIER_W-1:0]           cmp_tier_reg;
    logic [WAY_W-1:0]            cmp_way_reg;
    logic                        found_reg;
    logic [TIER_W-1:0]           found_tier_reg;
    logic [WAY_W-1:0]            found_way_reg;
    logic [DATA_BITS-1:0]        found_data_reg;
    logic [KEY_BITS-1:0]         carry_key_reg;
    logic [DATA_BITS-1:0]        carry_data_reg;
    logic [LVL_W-1:0]            level_reg;
    logic                        done_reg;
    logic                        hit_reg;
    logic [1:0]                  hit_tier_reg;
    logic [DATA_BITS-1:0]        data_out_reg;
    logic                        dropped_reg;
    logic [KEY_BITS-1:0]         dropped_key_reg;
    logic [DATA_BITS-1:0]        dropped_data_reg;

    logic [TIERS_W-1:0]          tiers_reg;
    logic [CAP_W-1:0]            cap_reg [NUM_CAP_REGS];

    // key/data store
    logic [ENTRY_W-1:0]          mem [SLOTS];
    logic [ENTRY_W-1:0]          mem_q_reg;
    logic                        rd_en;
    logic [SLOT_W-1:0]           rd_addr;
    logic                        wr_en;
    logic [SLOT_W-1:0]           wr_addr;
    logic [KEY_BITS-1:0]         q_key;
    logic [DATA_BITS-1:0]        q_data;

    // slot tracker hookup
    logic                            remove_en;
    logic                            push_en;
    logic [TIER_W-1:0]               op_tier;
    logic [WAY_W-1:0]                op_way;
    logic [TIER_W-1:0]               query_tier;
    logic [MAX_TIERS-1:0][WAYS-1:0]  slot_valid;
    logic [CNT_W-1:0]                tier_count;
    logic [WAY_W-1:0]                oldest_way;
    logic [WAY_W-1:0]                free_way;

    logic [LVL_W-1:0]            n_tiers;
    logic [CNT_W-1:0]            tier_cap;
    logic                        cmp_match;
    logic                        cmp_last;
    logic                        level_out;
    logic                        tier_full;

    function automatic logic [SLOT_W-1:0] slot_addr(logic [TIER_W-1:0] t,
                                                    logic [WAY_W-1:0] w);
        return SLOT_W'(int'(t) * WAYS + int'(w));
    endfunction

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign done         = done_reg;
    assign hit          = hit_reg;
    assign hit_tier     = hit_tier_reg;
    assign data_out     = data_out_reg;
    assign dropped      = dropped_reg;
    assign dropped_key  = dropped_key_reg;
    assign dropped_data = dropped_data_reg;

    assign q_key  = mem_q_reg[ENTRY_W-1:DATA_BITS];
    assign q_data = mem_q_reg[DATA_BITS-1:0];

    // clamp the active tier count
    always_comb
    begin
        if (tiers_reg == '0)
            n_tiers = LVL_W'(1);
        else if (int'(tiers_reg) > MAX_TIERS)
            n_tiers = LVL_W'(MAX_TIERS);
        else
            n_tiers = LVL_W'(tiers_reg);
    end

    assign query_tier = TIER_W'(level_reg);
    assign level_out  = (level_reg >= n_tiers);

    // capacity of the tier at the current level, clamped to 1..WAYS
    always_comb
    begin
        int c;
        c = WAYS;
        for (int i = 0; i < NUM_CAP_REGS; i++)
        begin
            if (int'(query_tier) == i)
                c = int'(cap_reg[i]);
        end
        if (c < 1)
            c = 1;
        if (c > WAYS)
            c = WAYS;
        tier_cap = CNT_W'(c);
    end

    assign tier_full = (tier_count >= tier_cap);

    assign cmp_match = cmp_vld_reg && slot_valid[cmp_tier_reg][cmp_way_reg]
                       && (q_key == key_reg);
    assign cmp_last  = (int'(cmp_tier_reg) == MAX_TIERS - 1)
                       && (int'(cmp_way_reg) == WAYS - 1);

    // memory port and slot tracker controls
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = slot_addr(iss_tier_reg, iss_way_reg);
        wr_en     = 1'b0;
        wr_addr   = slot_addr(query_tier, free_way);
        remove_en = 1'b0;
        push_en   = 1'b0;
        op_tier   = query_tier;
        op_way    = free_way;
        unique case (state_reg)
            ST_SCAN:
            begin
                rd_en = iss_on_reg;
            end
            ST_DECIDE:
            begin
                remove_en = found_reg && (mode_reg == 1'b0 || found_reg);
                op_tier   = found_tier_reg;
                op_way    = found_way_reg;
            end
            ST_INSERT:
            begin
                if (!level_out)
                begin
                    if (!tier_full)
                    begin
                        push_en = 1'b1;
                        wr_en   = 1'b1;
                    end
                    else
                    begin
                        remove_en = 1'b1;
                        op_way    = oldest_way;
                        rd_en     = 1'b1;
                        rd_addr   = slot_addr(query_tier, oldest_way);
                    end
                end
            end
            ST_SHIFT:
            begin
                push_en = 1'b1;
                wr_en   = 1'b1;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // key/data memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {carry_key_reg, carry_data_reg};
        if (rd_en)
            mem_q_reg <= mem[rd_addr];
    end

    mtlru_slots #(
        .MAX_TIERS (MAX_TIERS),
        .WAYS      (WAYS)
    ) u_slots (
        .clk        (clk),
        .rst_n      (rst_n),
        .remove_en  (remove_en),
        .push_en    (push_en),
        .op_tier    (op_tier),
        .op_way     (op_way),
        .query_tier (query_tier),
        .valid      (slot_valid),
        .count      (tier_count),
        .oldest_way (oldest_way),
        .free_way   (free_way)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tiers_reg <= TIERS_RESET;
            for (int i = 0; i < NUM_CAP_REGS; i++)
                cap_reg[i] <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TIERS: tiers_reg  <= cfg_data[TIERS_W-1:0];
                REG_CAP0:  cap_reg[0] <= cfg_data[CAP_W-1:0];
                REG_CAP1:  cap_reg[1] <= cfg_data[CAP_W-1:0];
                REG_CAP2:  cap_reg[2] <= cfg_data[CAP_W-1:0];
                REG_CAP3:  cap_reg[3] <= cfg_data[CAP_W-1:0];
                default:   tiers_reg  <= tiers_reg;
            endcase
        end
    end

    // sequencer: scan, remove hit, insert with demotion cascade
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            iss_on_reg  <= 1'b0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        mode_reg     <= mode;
                        key_reg      <= key;
                        data_reg     <= data_in;
                        iss_on_reg   <= 1'b1;
                        iss_tier_reg <= '0;
                        iss_way_reg  <= '0;
                        cmp_vld_reg  <= 1'b0;
                        found_reg    <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    // advance the read address one slot a cycle
                    cmp_vld_reg  <= iss_on_reg;
                    cmp_tier_reg <= iss_tier_reg;
                    cmp_way_reg  <= iss_way_reg;
                    if (iss_on_reg)
                    begin
                        if (int'(iss_way_reg) == WAYS - 1)
                        begin
                            iss_way_reg <= '0;
                            if (int'(iss_tier_reg) == MAX_TIERS - 1)
                                iss_on_reg <= 1'b0;
                            else
                                iss_tier_reg <= iss_tier_reg + 1'b1;
                        end
                        else
                        begin
                            iss_way_reg <= iss_way_reg + 1'b1;
                        end
                    end
                    // keep the first match
                    if (cmp_match && !found_reg)
                    begin
                        found_reg      <= 1'b1;
                        found_tier_reg <= cmp_tier_reg;
                        found_way_reg  <= cmp_way_reg;
                        found_data_reg <= q_data;
                    end
                    if (cmp_vld_reg && cmp_last)
                        state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    hit_reg          <= found_reg;
                    hit_tier_reg     <= found_reg ? 2'(found_tier_reg) : 2'd0;
                    data_out_reg     <= (mode_reg && found_reg) ? found_data_reg : '1;
                    dropped_reg      <= 1'b0;
                    dropped_key_reg  <= '0;
                    dropped_data_reg <= '0;
                    if (mode_reg == 1'b0 || found_reg)
                    begin
                        carry_key_reg  <= key_reg;
                        carry_data_reg <= mode_reg ? found_data_reg : data_reg;
                        level_reg      <= '0;
                        state_reg      <= ST_INSERT;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_INSERT:
                begin
                    if (level_out)
                    begin
                        // drop the entry pushed past the last tier
                        dropped_reg      <= 1'b1;
                        dropped_key_reg  <= carry_key_reg;
                        dropped_data_reg <= carry_data_reg;
                        done_reg         <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                    else if (!tier_full)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_SHIFT;
                    end
                end
                ST_SHIFT:
                begin
                    // place the carried entry, carry the evicted one down
                    carry_key_reg  <= q_key;
                    carry_data_reg <= q_data;
                    level_reg      <= level_reg + 1'b1;
                    state_reg      <= ST_INSERT;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/mtlru_checker.sv */
// ----------------------------------------------------------------------------
// mtlru_checker: port-level checks for the multi-tier LRU cache
// Watches the command and result ports and reports protocol slips.
// ----------------------------------------------------------------------------
module mtlru_checker
    import mtlru_pkg::*;
#(
    parameter int KEY_BITS  = DEF_KEY_BITS,
    parameter int DATA_BITS = DEF_DATA_BITS
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic                  hit,
    input logic [1:0]            hit_tier,
    input logic [KEY_BITS-1:0]   dropped_key,
    input logic [DATA_BITS-1:0]  dropped_data,
    input logic                  dropped
);

    // an accepted item keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted item");

    // a result ends the item
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result without item in flight");

    // one result per item
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result repeated");

    // a miss reports tier zero
    a_miss_tier: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> hit_tier == 2'd0)
        else $error("tier reported on miss");

    // nothing dropped means zero drop payload
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !dropped |-> dropped_key == '0 && dropped_data == '0)
        else $error("drop payload without drop");

endmodule

bind multi_tier_lru_cache mtlru_checker #(
    .KEY_BITS  (KEY_BITS),
    .DATA_BITS (DATA_BITS)
) u_mtlru_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .hit          (hit),
    .hit_tier     (hit_tier),
    .dropped_key  (dropped_key),
    .dropped_data (dropped_data),
    .dropped      (dropped)
);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the multi-tier LRU cache
// Drives put/get items through the command port and checks every result
// against a tiered LRU predictor. A directed table comes first, then random
// phases over several tier and capacity settings.
// ----------------------------------------------------------------------------
module testbench;
    import mtlru_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT = DEF_MAX_TIERS;
    localparam int NW = DEF_WAYS;
    localparam int NS = NT * NW;
    localparam int WATCHDOG = 5000;

    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    typedef struct packed {
        logic        hit;
        logic [1:0]  hit_tier;
        logic [31:0] data_out;
        logic        dropped;
        logic [31:0] dropped_key;
        logic [31:0] dropped_data;
    } lookup_t;

    typedef struct {
        logic        op;
        logic [31:0] k;
        logic [31:0] d;
        logic        chk;
        lookup_t     res;
    } row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic mode = 0;
    logic signed [31:0] key = 0;
    logic signed [31:0] data_in = 0;
    logic cfg_valid = 0;
    logic [CFG_IDX_W-1:0] cfg_index = 0;
    logic [CFG_DATA_W-1:0] cfg_data = 0;
    logic busy, done, hit, dropped, cfg_ready;
    logic [1:0] hit_tier;
    logic signed [31:0] data_out, dropped_key, dropped_data;

    multi_tier_lru_cache DUT (.*);

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    // predictor state and configuration
    logic [2:0]  pm_tiers;
    logic [3:0]  pm_cap [NT];
    logic        pm_valid [NS];
    logic [31:0] pm_key [NS];
    logic [31:0] pm_data [NS];
    int          pm_age [NS];

    lookup_t pending [$];
    int errors = 0;
    int idle_cycles = 0;
    int calm = 0;
    logic [31:0] recent [$];

    function automatic int tier_cap(int t);
        int c;
        c = pm_cap[t];
        if (c < 1) c = 1;
        if (c > NW) c = NW;
        return c;
    endfunction

    function automatic void drop_slot(int s);
        int t;
        int a;
        t = s / NW;
        a = pm_age[s];
        pm_valid[s] = 0;
        pm_age[s] = 0;
        for (int w = 0; w < NW; w++)
            if (pm_valid[t*NW+w] && pm_age[t*NW+w] > a) pm_age[t*NW+w]--;
    endfunction

    function automatic void place_front(int t, logic [31:0] k, logic [31:0] d);
        int f;
        f = -1;
        for (int w = 0; w < NW; w++)
            if (!pm_valid[t*NW+w] && f < 0) f = t*NW+w;
        if (f < 0) return;
        for (int w = 0; w < NW; w++)
            if (pm_valid[t*NW+w]) pm_age[t*NW+w]++;
        pm_valid[f] = 1;
        pm_key[f] = k;
        pm_data[f] = d;
        pm_age[f] = 0;
    endfunction

    function automatic void cascade(logic [31:0] k, logic [31:0] d, ref lookup_t r);
        int n;
        int cnt;
        int best;
        logic [31:0] ek, ed;
        n = pm_tiers;
        if (n < 1) n = 1;
        if (n > NT) n = NT;
        for (int lv = 0; ; lv++)
        begin
            if (lv >= n)
            begin
                r.dropped = 1;
                r.dropped_key = k;
                r.dropped_data = d;
                return;
            end
            cnt = 0;
            for (int w = 0; w < NW; w++) if (pm_valid[lv*NW+w]) cnt++;
            if (cnt < tier_cap(lv))
            begin
                place_front(lv, k, d);
                return;
            end
            best = -1;
            for (int w = 0; w < NW; w++)
                if (pm_valid[lv*NW+w] && (best < 0 || pm_age[lv*NW+w] > pm_age[best]))
                    best = lv*NW+w;
            ek = pm_key[best];
            ed = pm_data[best];
            drop_slot(best);
            place_front(lv, k, d);
            k = ek;
            d = ed;
        end
    endfunction

    function automatic lookup_t predict_lookup(logic op, logic [31:0] k, logic [31:0] d);
        lookup_t r;
        int s;
        logic [31:0] v;
        r = '{hit: 0, hit_tier: 0, data_out: 32'hFFFF_FFFF, dropped: 0,
              dropped_key: 0, dropped_data: 0};
        s = -1;
        for (int i = 0; i < NS; i++)
            if (s < 0 && pm_valid[i] && pm_key[i] == k) s = i;
        if (s >= 0)
        begin
            r.hit = 1;
            r.hit_tier = 2'(s / NW);
        end
        if (op == OP_PUT)
        begin
            if (s >= 0) drop_slot(s);
            cascade(k, d, r);
        end
        else if (s >= 0)
        begin
            v = pm_data[s];
            drop_slot(s);
            cascade(k, v, r);
            r.data_out = v;
        end
        return r;
    endfunction

    // check each result against the oldest expectation
    always @(posedge clk)
    begin
        lookup_t e;
        if (rst_n && done)
        begin
            if (pending.size() == 0)
            begin
                $error("result with no expectation waiting");
                errors++;
            end
            else
            begin
                e = pending.pop_front();
                if (hit !== e.hit)
                begin
                    $error("hit exp %0h got %0h", e.hit, hit); errors++;
                end
                if (hit_tier !== e.hit_tier)
                begin
                    $error("hit_tier exp %0h got %0h", e.hit_tier, hit_tier); errors++;
                end
                if (data_out !== e.data_out)
                begin
                    $error("data_out exp %0h got %0h", e.data_out, data_out); errors++;
                end
                if (dropped !== e.dropped)
                begin
                    $error("dropped exp %0h got %0h", e.dropped, dropped); errors++;
                end
                if (dropped_key !== e.dropped_key)
                begin
                    $error("dropped_key exp %0h got %0h", e.dropped_key, dropped_key);
                    errors++;
                end
                if (dropped_data !== e.dropped_data)
                begin
                    $error("dropped_data exp %0h got %0h", e.dropped_data, dropped_data);
                    errors++;
                end
            end
        end
    end

    // watchdog: count cycles with no accepted item, config write or result
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(logic op, logic [31:0] k, logic [31:0] d, logic chk,
                             lookup_t res);
        lookup_t p;
        // step past the edge that released the previous item
        @(posedge clk);
        // random gap before the item, none during the calm stretch
        while (calm == 0 && $urandom_range(99) < 31) @(posedge clk);
        start <= 1;
        mode <= op;
        key <= k;
        data_in <= d;
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 0;
        mode <= $urandom;
        key <= $urandom;
        data_in <= $urandom;
        p = predict_lookup(op, k, d);
        if (chk && p !== res)
        begin
            $error("directed row disagrees with predictor: exp %0h pred %0h", res, p);
            errors++;
        end
        pending.push_back(chk ? res : p);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        // step past the edge that released the previous write
        @(posedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        if (idx == REG_TIERS) pm_tiers = v[2:0];
        else pm_cap[idx - REG_CAP0] = v;
    endtask

    task automatic drain();
        while (pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_key();
        if (recent.size() != 0 && $urandom_range(99) < 60)
            return recent[$urandom_range(recent.size() - 1)];
        return $urandom_range(99) < 50 ? 32'($urandom_range(23)) : $urandom;
    endfunction

    localparam lookup_t MISS_PUT = '{0, 0, 32'hFFFF_FFFF, 0, 0, 0};

    row_t rows [] = '{
        '{OP_GET, 32'h0000_0000, 32'h0, 1, MISS_PUT},
        '{OP_GET, 32'h8000_0000, 32'h1234_5678, 1, MISS_PUT},
        '{OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1, MISS_PUT},
        '{OP_GET, 32'h8000_0000, 32'h0, 1, '{1, 0, 32'h7FFF_FFFF, 0, 0, 0}},
        '{OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1, MISS_PUT},
        '{OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, MISS_PUT},
        '{OP_PUT, 32'h1, 32'h11, 0, MISS_PUT},
        '{OP_PUT, 32'h2, 32'h22, 0, MISS_PUT},
        '{OP_PUT, 32'h3, 32'h33, 0, MISS_PUT},
        '{OP_PUT, 32'h4, 32'h44, 0, MISS_PUT},
        '{OP_PUT, 32'h5, 32'h55, 0, MISS_PUT},
        '{OP_GET, 32'h8000_0000, 32'h0, 0, MISS_PUT},
        '{OP_GET, 32'h2, 32'hFFFF_FFFF, 0, MISS_PUT},
        '{OP_PUT, 32'h3, 32'h0, 0, MISS_PUT},
        '{OP_GET, 32'h5, 32'h0, 0, MISS_PUT},
        '{OP_PUT, 32'h6, 32'h66, 0, MISS_PUT},
        '{OP_PUT, 32'h7, 32'h77, 0, MISS_PUT},
        '{OP_GET, 32'h1, 32'h0, 0, MISS_PUT},
        '{OP_GET, 32'h9, 32'h0, 0, MISS_PUT}
    };

    initial
    begin
        int tv;
        pm_tiers = TIERS_RESET;
        for (int t = 0; t < NT; t++) pm_cap[t] = CAP_RESET;
        for (int i = 0; i < NS; i++)
        begin
            pm_valid[i] = 0; pm_key[i] = 0; pm_data[i] = 0; pm_age[i] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed table at reset configuration
        foreach (rows[i]) send_item(rows[i].op, rows[i].k, rows[i].d, rows[i].chk, rows[i].res);
        drain();

        // random phases; keep entries across reconfiguration
        for (int ph = 0; ph < 10; ph++)
        begin
            tv = (ph == 0) ? 1 : (ph == 1) ? 4 : (ph == 2) ? 0 : (ph == 3) ? 7 :
                 $urandom_range(1, 4);
            write_reg(REG_TIERS, CFG_DATA_W'(tv));
            for (int t = 0; t < NT; t++)
                write_reg(CFG_IDX_W'(REG_CAP0 + t),
                          ph == 0 ? 4'd1 : ph == 1 ? 4'd8 : ph == 2 ? 4'd0 :
                          ph == 3 ? 4'd15 : 4'($urandom_range(1, 8)));
            calm = (ph == 5);
            for (int n = 0; n < 80; n++)
            begin
                logic [31:0] k;
                k = pick_key();
                recent.push_back(k);
                if (recent.size() > 40) void'(recent.pop_front());
                send_item($urandom_range(99) < 50 ? OP_PUT : OP_GET, k, $urandom, 0,
                          MISS_PUT);
            end
            calm = 0;
            drain();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
